// ----- design/bxt_pkg.sv -----
// Shared constants, types and a helper function of the Bezier inverse solver.
package bxt_pkg;

  localparam int T_FRAC_BITS = 24;
  localparam int VALUE_BITS  = 32;

  localparam int DATA_W = 32;
  localparam int TW     = T_FRAC_BITS + 1;
  localparam int MAG_W  = DATA_W + 1;
  localparam int PROD_W = MAG_W + TW;
  localparam int TOL_W  = 16;
  localparam int CFG_AW = 3;
  localparam int STEP_W = $clog2(T_FRAC_BITS);

  localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

  localparam longint V_HI = (longint'(1) <<< (VALUE_BITS - 1)) - longint'(1);
  localparam longint V_LO = -V_HI - longint'(1);

  // Register word index decoded from paddr.
  localparam logic REG_TOL = 1'b0;

  localparam logic CMD_EVAL  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RANGE,
    S_CLAMP,
    S_LOAD,
    S_ISSUE,
    S_WAIT,
    S_ALIGN,
    S_DIFF,
    S_CHECK,
    S_OUT
  } state_t;

  // Saturate a value to the signed VALUE_BITS range.
  function automatic logic signed [DATA_W-1:0] sat_value(input logic signed [DATA_W-1:0] v);
    longint w;
    w = longint'(v);
    if (VALUE_BITS < DATA_W) begin
      if (w > V_HI) begin
        w = V_HI;
      end else if (w < V_LO) begin
        w = V_LO;
      end
    end
    return DATA_W'(w);
  endfunction

endpackage

// ----- design/bxt_lerp_unit.sv -----
// Shared linear interpolation unit: p + (q - p) * t, rounded.
module bxt_lerp_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               issue,
  input  logic signed [bxt_pkg::DATA_W-1:0]  p,
  input  logic signed [bxt_pkg::DATA_W-1:0]  q,
  input  logic        [bxt_pkg::TW-1:0]      t,
  output logic                               done,
  output logic signed [bxt_pkg::DATA_W-1:0]  res
);
  import bxt_pkg::*;

  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (T_FRAC_BITS - 1);

  logic signed [MAG_W-1:0]  d_up;
  logic signed [MAG_W-1:0]  d_dn;
  logic                     s1_r;
  logic                     s2_r;
  logic        [MAG_W-1:0]  mag_r;
  logic                     neg_r;
  logic                     neg2_r;
  logic signed [DATA_W-1:0] p_r;
  logic signed [DATA_W-1:0] p2_r;
  logic        [TW-1:0]     t_r;
  logic        [PROD_W-1:0] prod_r;
  logic        [PROD_W-1:0] rnd;
  logic signed [MAG_W:0]    p_ext;
  logic signed [MAG_W:0]    r_ext;
  logic signed [MAG_W:0]    sum;

  // Both differences are formed so the magnitude needs only a select.
  assign d_up = MAG_W'(q) - MAG_W'(p);
  assign d_dn = MAG_W'(p) - MAG_W'(q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0;
      s2_r <= 1'b0;
    end else begin
      s1_r <= issue;
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      mag_r <= d_up[MAG_W-1] ? d_dn : d_up;
      neg_r <= d_up[MAG_W-1];
      p_r   <= p;
      t_r   <= t;
    end
    if (s1_r) begin
      prod_r <= mag_r * t_r;
      neg2_r <= neg_r;
      p2_r   <= p_r;
    end
  end

  // Magnitude rounded half up, then the sign is applied.
  always_comb begin
    rnd   = (prod_r + HALF) >> T_FRAC_BITS;
    p_ext = (MAG_W + 1)'(p2_r);
    r_ext = $signed({1'b0, rnd[MAG_W-1:0]});
    sum   = neg2_r ? (p_ext - r_ext) : (p_ext + r_ext);
  end

  assign done = s2_r;
  assign res  = sum[DATA_W-1:0];

endmodule

// ----- design/bxt_cfg_regs.sv -----
// APB-style configuration register holding the match tolerance.
module bxt_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bxt_pkg::CFG_AW-1:0]    paddr,
  input  logic [bxt_pkg::DATA_W-1:0]    pwdata,
  output logic [bxt_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output logic [bxt_pkg::TOL_W-1:0]     tolerance
);
  import bxt_pkg::*;

  logic [TOL_W-1:0] tol_r;
  logic [TOL_W-1:0] tol_nxt;
  logic             wr_en;

  // The low address bits select a byte within the word and are ignored.
  assign wr_en = psel && penable && pwrite && (paddr[CFG_AW-1] == REG_TOL);

  always_comb begin
    tol_nxt = tol_r;
    if (wr_en) begin
      tol_nxt = pwdata[TOL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else begin
      tol_r <= tol_nxt;
    end
  end

  assign prdata    = (paddr[CFG_AW-1] == REG_TOL) ? DATA_W'(tol_r) : '0;
  assign pready    = 1'b1;
  assign tolerance = tol_r;

endmodule

// ----- design/bezier_x_to_t_bisection_unit.sv -----
// Top level: Bezier evaluator and bisection solver for t from x.
//
// Usage: an item on the in_ channel carries a command, a cubic flag, control
// values point_a..point_d (signed Q16.16) and an operand. Command 0 evaluates
// the curve at t (Q1.24, clamped to [0, 1.0]); command 1 clamps x to the span
// of the first and last points and bisects t until the curve is within
// match_tolerance of x. One result item per input item leaves on out_.
// The tolerance register sits at byte address 0 of the APB-style port.
// All interpolation goes through one shared unit with a multiplier; the
// difference and clamp steps are done in the control logic. Command 1 runs
// up to 24 bisection steps, each a full curve evaluation, and stops early
// once the curve is within the tolerance.
// in_stall is high from acceptance until the result has moved into the output
// register; one item is worked on at a time. A new item may be taken while
// the previous result waits on a stalled receiver. If the receiver stalls,
// the result holds on out_result and the block waits before handing over the
// next one. Reset empties the block and sets the tolerance to 0.
module bezier_x_to_t_bisection_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic                              in_cubic,
  input  logic signed [bxt_pkg::DATA_W-1:0] in_point_a,
  input  logic signed [bxt_pkg::DATA_W-1:0] in_point_b,
  input  logic signed [bxt_pkg::DATA_W-1:0] in_point_c,
  input  logic signed [bxt_pkg::DATA_W-1:0] in_point_d,
  input  logic signed [bxt_pkg::DATA_W-1:0] in_operand,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bxt_pkg::DATA_W-1:0] out_result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bxt_pkg::CFG_AW-1:0]        paddr,
  input  logic [bxt_pkg::DATA_W-1:0]        pwdata,
  output logic [bxt_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import bxt_pkg::*;

  state_t                   state_r, state_nxt;
  logic                     cmd_r, cmd_nxt;
  logic                     cubic_r, cubic_nxt;
  logic signed [DATA_W-1:0] pts_r [4];
  logic signed [DATA_W-1:0] pts_nxt [4];
  logic        [DATA_W-1:0] op_r, op_nxt;
  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic signed [DATA_W-1:0] lo_r, lo_nxt;
  logic signed [DATA_W-1:0] hi_r, hi_nxt;
  logic signed [DATA_W-1:0] v_r [4];
  logic signed [DATA_W-1:0] v_nxt [4];
  logic        [TW-1:0]     t_r, t_nxt;
  logic        [TW-1:0]     bottom_r, bottom_nxt;
  logic        [TW-1:0]     top_r, top_nxt;
  logic        [STEP_W-1:0] step_r, step_nxt;
  logic        [1:0]        lvl_r, lvl_nxt;
  logic        [1:0]        cnt_r, cnt_nxt;
  logic signed [DATA_W-1:0] test_r, test_nxt;
  logic        [MAG_W-1:0]  err_r, err_nxt;
  logic                     xgt_r, xgt_nxt;
  logic signed [DATA_W-1:0] res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_result_r, out_result_nxt;

  logic                     lerp_issue;
  logic                     lerp_done;
  logic signed [DATA_W-1:0] lerp_res;
  logic        [TOL_W-1:0]  tolerance;
  logic        [TW:0]       sum_bt;
  logic        [TW-1:0]     mid;
  logic        [TW-1:0]     t_clamped;
  logic signed [DATA_W-1:0] last_pt;

  bxt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .tolerance (tolerance)
  );

  bxt_lerp_unit u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (lerp_issue),
    .p     (v_r[0]),
    .q     (v_r[1]),
    .t     (t_r),
    .done  (lerp_done),
    .res   (lerp_res)
  );

  assign lerp_issue = (state_r == S_ISSUE);

  assign sum_bt  = {1'b0, bottom_r} + {1'b0, top_r};
  assign mid     = sum_bt[TW:1];
  assign last_pt = cubic_r ? pts_r[3] : pts_r[2];

  always_comb begin
    if (op_r[DATA_W-1]) begin
      t_clamped = '0;
    end else if (op_r > DATA_W'(T_ONE)) begin
      t_clamped = T_ONE;
    end else begin
      t_clamped = op_r[TW-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    cubic_nxt      = cubic_r;
    pts_nxt        = pts_r;
    op_nxt         = op_r;
    x_nxt          = x_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    v_nxt          = v_r;
    t_nxt          = t_r;
    bottom_nxt     = bottom_r;
    top_nxt        = top_r;
    step_nxt       = step_r;
    lvl_nxt        = lvl_r;
    cnt_nxt        = cnt_r;
    test_nxt       = test_r;
    err_nxt        = err_r;
    xgt_nxt        = xgt_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_result_nxt = out_result_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_command;
          cubic_nxt  = in_cubic;
          pts_nxt[0] = sat_value(in_point_a);
          pts_nxt[1] = sat_value(in_point_b);
          pts_nxt[2] = sat_value(in_point_c);
          pts_nxt[3] = sat_value(in_point_d);
          op_nxt     = in_operand;
          step_nxt   = '0;
          bottom_nxt = '0;
          top_nxt    = T_ONE;
          state_nxt  = (in_command == CMD_SOLVE) ? S_RANGE : S_LOAD;
        end
      end

      S_RANGE: begin
        if (pts_r[0] < last_pt) begin
          lo_nxt = pts_r[0];
          hi_nxt = last_pt;
        end else begin
          lo_nxt = last_pt;
          hi_nxt = pts_r[0];
        end
        x_nxt     = sat_value($signed(op_r));
        state_nxt = S_CLAMP;
      end

      S_CLAMP: begin
        if (x_r < lo_r) begin
          x_nxt = lo_r;
        end else if (x_r > hi_r) begin
          x_nxt = hi_r;
        end
        state_nxt = S_LOAD;
      end

      S_LOAD: begin
        v_nxt     = pts_r;
        lvl_nxt   = cubic_r ? 2'd3 : 2'd2;
        cnt_nxt   = '0;
        t_nxt     = (cmd_r == CMD_SOLVE) ? mid : t_clamped;
        state_nxt = S_ISSUE;
      end

      S_ISSUE: begin
        state_nxt = S_WAIT;
      end

      // Each finished step shifts the working values down one place; the
      // new value enters at the end.
      S_WAIT: begin
        if (lerp_done) begin
          v_nxt[0] = v_r[1];
          v_nxt[1] = v_r[2];
          v_nxt[2] = v_r[3];
          v_nxt[3] = lerp_res;
          if (cnt_r + 2'd1 == lvl_r) begin
            if (lvl_r == 2'd1) begin
              test_nxt  = lerp_res;
              res_nxt   = lerp_res;
              state_nxt = (cmd_r == CMD_SOLVE) ? S_DIFF : S_OUT;
            end else begin
              state_nxt = S_ALIGN;
            end
          end else begin
            cnt_nxt   = cnt_r + 2'd1;
            state_nxt = S_ISSUE;
          end
        end
      end

      // Drop the stale leading values so the new level starts at slot 0.
      S_ALIGN: begin
        case (lvl_r)
          2'd3: begin
            v_nxt[0] = v_r[1];
            v_nxt[1] = v_r[2];
            v_nxt[2] = v_r[3];
          end
          default: begin
            v_nxt[0] = v_r[2];
            v_nxt[1] = v_r[3];
          end
        endcase
        lvl_nxt   = lvl_r - 2'd1;
        cnt_nxt   = '0;
        state_nxt = S_ISSUE;
      end

      S_DIFF: begin
        xgt_nxt = (x_r > test_r);
        if (x_r > test_r) begin
          err_nxt = MAG_W'(x_r) - MAG_W'(test_r);
        end else begin
          err_nxt = MAG_W'(test_r) - MAG_W'(x_r);
        end
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        if (err_r <= MAG_W'(tolerance)) begin
          res_nxt   = DATA_W'(t_r);
          state_nxt = S_OUT;
        end else begin
          if (xgt_r) begin
            bottom_nxt = t_r;
          end else begin
            top_nxt = t_r;
          end
          if (step_r == STEP_W'(T_FRAC_BITS - 1)) begin
            res_nxt   = xgt_r ? DATA_W'(t_r) : DATA_W'(bottom_r);
            state_nxt = S_OUT;
          end else begin
            step_nxt  = step_r + STEP_W'(1);
            state_nxt = S_LOAD;
          end
        end
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = res_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    cubic_r      <= cubic_nxt;
    pts_r        <= pts_nxt;
    op_r         <= op_nxt;
    x_r          <= x_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    v_r          <= v_nxt;
    t_r          <= t_nxt;
    bottom_r     <= bottom_nxt;
    top_r        <= top_nxt;
    step_r       <= step_nxt;
    lvl_r        <= lvl_nxt;
    cnt_r        <= cnt_nxt;
    test_r       <= test_nxt;
    err_r        <= err_nxt;
    xgt_r        <= xgt_nxt;
    res_r        <= res_nxt;
    out_result_r <= out_result_nxt;
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// ----- design/bxt_checker.sv -----
// Port-level checker for the Bezier solver, bound to the top level.
module bxt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [bxt_pkg::DATA_W-1:0] out_result
);

  // Only one item is in flight, so an accepted item closes the input.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an item was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_result)))
    else $error("stalled result changed or vanished");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("block not empty after reset");

  // The input reopens only in the cycle the result is handed to the output.
  a_reopen_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(in_stall) && $past(rst_n)) |-> out_valid)
    else $error("input reopened without a result");

endmodule

bind bezier_x_to_t_bisection_unit bxt_checker u_bxt_checker (.*);
